/* sv/sadsd_pkg.sv */
`default_nettype none
package sadsd_pkg;

  localparam int MAX_GRID_WIDTH  = 1024;
  localparam int MAX_DISPARITIES = 64;
  localparam int MAX_RADIUS      = 7;
  localparam int COST_BITS       = 10;
  localparam int MAX_HEIGHT      = 4096;
  localparam int RING_ROWS       = 2 * MAX_RADIUS + 1;

  localparam int COL_W    = $clog2(MAX_GRID_WIDTH);
  localparam int DISP_W   = $clog2(MAX_DISPARITIES);
  localparam int RING_W   = $clog2(RING_ROWS);
  localparam int ROW_W    = 13;
  localparam int VSUM_W   = 14;
  localparam int WSUM_W   = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int COST_DEPTH = RING_ROWS * MAX_GRID_WIDTH * MAX_DISPARITIES;
  localparam int COL_DEPTH  = MAX_GRID_WIDTH * MAX_DISPARITIES;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEFCOST = 3'd5;

  localparam logic [2:0]          RST_RADIUS  = 3'd2;
  localparam logic [9:0]          RST_WIDTH   = 10'd640;
  localparam logic [12:0]         RST_HEIGHT  = 13'd480;
  localparam logic [6:0]          RST_BASE    = 7'd0;
  localparam logic [6:0]          RST_COUNT   = 7'd16;
  localparam logic [COST_BITS-1:0] RST_DEFCOST = 10'd100;

  typedef logic [COST_BITS-1:0] cost_t;
  typedef logic [WSUM_W-1:0]    wsum_t;

endpackage
`default_nettype wire

/* sv/sadsd_in_if.sv */
`default_nettype none
interface sadsd_in_if;
  import sadsd_pkg::*;
  logic  valid;
  logic  ready;
  cost_t pair_cost;
  logic  pair_valid;
  modport source (output valid, output pair_cost, output pair_valid, input ready);
  modport sink (input valid, input pair_cost, input pair_valid, output ready);
endinterface
`default_nettype wire

/* sv/sadsd_out_if.sv */
`default_nettype none
interface sadsd_out_if;
  import sadsd_pkg::*;
  logic              valid;
  logic              ready;
  logic signed [7:0] best_disparity;
  wsum_t             best_window_cost;
  logic              frame_end;
  modport source (output valid, output best_disparity, output best_window_cost,
                  output frame_end, input ready);
  modport sink (input valid, input best_disparity, input best_window_cost,
                input frame_end, output ready);
endinterface
`default_nettype wire

/* sv/sadsd_cfg_if.sv */
`default_nettype none
interface sadsd_cfg_if;
  import sadsd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/sad_window_stereo_disparity.sv */
`default_nettype none
// SAD block-matching stereo core with winner-take-all. The source streams one
// matching cost word per cycle over the padded grid, rows outermost, then
// columns, then disparities; the core accepts one word every cycle and keeps
// one word per cycle of throughput as long as the result side takes its words.
// Each word passes through a pipeline: the cost ring store and the
// column and window sum stores are read in the accept cycle, the running
// column and window sums are updated and written back in the following stage,
// and the minimum search and result register follow. Back-to-back updates of the same
// store entry are forwarded. One result word leaves after the last disparity
// of every window centre inside the image, with frame_end on the last pixel.
// Any configuration write to a known register restarts the frame; no store
// needs clearing after reset.
module sad_window_stereo_disparity (
  input  logic              clk,
  input  logic              rst_n,
  sadsd_in_if.sink          in_s,
  sadsd_out_if.source       out_m,
  sadsd_cfg_if.sink         cfg_s
);
  import sadsd_pkg::*;

  typedef struct packed {
    logic first_row;
    logic sub_row;
    logic first_col;
    logic sub_col;
    logic zone;
    logic last;
    logic fend;
    logic hit_a;
    logic hit_b;
    logic hit_w;
  } s1_flags_t;

  logic [2:0]  radius_r;
  logic [9:0]  width_r;
  logic [12:0] height_r;
  logic [6:0]  base_r;
  logic [6:0]  count_r;
  cost_t       dcost_r;

  logic [COL_W-1:0]  gc_r;
  logic [ROW_W-1:0]  gr_r;
  logic [DISP_W-1:0] di_r;
  logic [RING_W-1:0] ring_r;

  logic [3:0]  span;
  logic [6:0]  nd;
  logic [9:0]  w_in;
  logic [10:0] w_lim;
  logic [10:0] gw;
  logic [12:0] h_in;
  logic [13:0] h_cl;
  logic [13:0] gh;

  logic advance, accept, cfg_restart;
  logic di_last, col_last, row_last;
  logic [4:0]        ring_t;
  logic [RING_W-1:0] ring_old;
  logic [RING_W+COL_W+DISP_W-1:0] cost_wa, cost_ra;
  logic [COL_W+DISP_W-1:0]        col_a, col_b;
  logic [COL_W-1:0]               gc_left;
  cost_t                          cost_in;

  logic [COST_BITS-1:0] cost_rd;
  logic [VSUM_W-1:0]    col_rd_a, col_rd_b;
  wsum_t                win_rd;

  logic [COST_BITS-1:0] cost_mem [0:COST_DEPTH-1];
  logic [VSUM_W-1:0]    col_mem [0:COL_DEPTH-1];
  wsum_t                win_mem [0:MAX_DISPARITIES-1];

  logic              s1_v_r;
  cost_t             s1_cost_r;
  logic [COL_W-1:0]  s1_gc_r;
  logic [DISP_W-1:0] s1_di_r;
  s1_flags_t         s1_f_r, s1_f_nxt;
  logic              s1_wr;

  logic [VSUM_W-1:0] fwd_v_r;
  wsum_t             fwd_w_r;
  logic [VSUM_W-1:0] v_old, v_left, v_new;
  wsum_t             w_old, w_new;

  logic              s2_v_r;
  wsum_t             s2_w_r;
  logic [DISP_W-1:0] s2_di_r;
  logic              s2_zone_r, s2_last_r, s2_fend_r;

  wsum_t             best_r, best_nxt;
  logic [DISP_W-1:0] bidx_r, bidx_nxt;
  logic              take;
  wsum_t             cand_c;
  logic [DISP_W-1:0] cand_i;
  logic              emit;

  logic              out_v_r;
  logic [7:0]        out_disp_r;
  wsum_t             out_cost_r;
  logic              out_fend_r;

  assign span  = {radius_r, 1'b0};
  assign nd    = (count_r == 7'd0) ? 7'd1 :
                 (count_r > 7'(MAX_DISPARITIES)) ? 7'(MAX_DISPARITIES) : count_r;
  assign w_in  = (width_r == 10'd0) ? 10'd1 : width_r;
  assign w_lim = 11'(MAX_GRID_WIDTH) - 11'(span);
  assign gw    = ((11'(w_in) > w_lim) ? w_lim : 11'(w_in)) + 11'(span);
  assign h_in  = (height_r == 13'd0) ? 13'd1 : height_r;
  assign h_cl  = (14'(h_in) > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : 14'(h_in);
  assign gh    = h_cl + 14'(span);

  assign advance   = !out_v_r || out_m.ready;
  assign in_s.ready = advance;
  assign accept    = in_s.valid && advance;
  assign cfg_s.ready = 1'b1;
  assign cfg_restart = cfg_s.valid &&
                       (cfg_s.index == REG_RADIUS || cfg_s.index == REG_WIDTH ||
                        cfg_s.index == REG_HEIGHT || cfg_s.index == REG_BASE ||
                        cfg_s.index == REG_COUNT || cfg_s.index == REG_DEFCOST);

  assign di_last  = (7'(di_r) + 7'd1) >= nd;
  assign col_last = (11'(gc_r) + 11'd1) >= gw;
  assign row_last = (14'(gr_r) + 14'd1) >= gh;

  assign ring_t   = 5'(ring_r) + 5'd14 - 5'(span);
  assign ring_old = (ring_t >= 5'(RING_ROWS)) ? RING_W'(ring_t - 5'(RING_ROWS))
                                              : RING_W'(ring_t);
  assign cost_wa  = {ring_r, gc_r, di_r};
  assign cost_ra  = {ring_old, gc_r, di_r};
  assign gc_left  = gc_r - COL_W'(span) - COL_W'(1);
  assign col_a    = {gc_r, di_r};
  assign col_b    = {gc_left, di_r};
  assign cost_in  = in_s.pair_valid ? in_s.pair_cost : dcost_r;

  always_comb begin
    s1_f_nxt.first_row = (gr_r == '0);
    s1_f_nxt.sub_row   = (gr_r > ROW_W'(span));
    s1_f_nxt.first_col = (gc_r == '0);
    s1_f_nxt.sub_col   = (gc_r > COL_W'(span));
    s1_f_nxt.zone      = (gr_r >= ROW_W'(span)) && (gc_r >= COL_W'(span));
    s1_f_nxt.last      = di_last;
    s1_f_nxt.fend      = row_last && col_last;
    s1_f_nxt.hit_a     = s1_v_r && ({s1_gc_r, s1_di_r} == col_a);
    s1_f_nxt.hit_b     = s1_v_r && ({s1_gc_r, s1_di_r} == col_b);
    s1_f_nxt.hit_w     = s1_v_r && (s1_di_r == di_r);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cost_rd <= cost_mem[cost_ra];
      cost_mem[cost_wa] <= cost_in;
    end
  end

  assign s1_wr = s1_v_r && advance;

  always_ff @(posedge clk) begin
    if (accept) begin
      col_rd_a <= col_mem[col_a];
      col_rd_b <= col_mem[col_b];
    end
    if (s1_wr) begin
      col_mem[{s1_gc_r, s1_di_r}] <= v_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_rd <= win_mem[di_r];
    end
    if (s1_wr) begin
      win_mem[s1_di_r] <= w_new;
    end
  end

  always_comb begin
    v_old  = s1_f_r.hit_a ? fwd_v_r : col_rd_a;
    v_left = s1_f_r.hit_b ? fwd_v_r : col_rd_b;
    w_old  = s1_f_r.hit_w ? fwd_w_r : win_rd;
    if (s1_f_r.first_row) begin
      v_new = VSUM_W'(s1_cost_r);
    end else begin
      v_new = v_old + VSUM_W'(s1_cost_r) - (s1_f_r.sub_row ? VSUM_W'(cost_rd) : '0);
    end
    if (s1_f_r.first_col) begin
      w_new = WSUM_W'(v_new);
    end else begin
      w_new = w_old + WSUM_W'(v_new) - (s1_f_r.sub_col ? WSUM_W'(v_left) : '0);
    end
  end

  always_comb begin
    take   = (s2_di_r == '0) || (s2_w_r < best_r);
    cand_c = take ? s2_w_r : best_r;
    cand_i = take ? s2_di_r : bidx_r;
    emit   = s2_v_r && s2_zone_r && s2_last_r;
    best_nxt = best_r;
    bidx_nxt = bidx_r;
    if (s2_v_r && s2_zone_r) begin
      if (s2_last_r) begin
        best_nxt = '1;
        bidx_nxt = '0;
      end else begin
        best_nxt = cand_c;
        bidx_nxt = cand_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RST_RADIUS;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      base_r   <= RST_BASE;
      count_r  <= RST_COUNT;
      dcost_r  <= RST_DEFCOST;
      gc_r     <= '0;
      gr_r     <= '0;
      di_r     <= '0;
      ring_r   <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      best_r   <= '1;
      bidx_r   <= '0;
    end else begin
      if (cfg_restart) begin
        case (cfg_s.index)
          REG_RADIUS:  radius_r <= cfg_s.data[2:0];
          REG_WIDTH:   width_r  <= cfg_s.data[9:0];
          REG_HEIGHT:  height_r <= cfg_s.data[12:0];
          REG_BASE:    base_r   <= cfg_s.data[6:0];
          REG_COUNT:   count_r  <= cfg_s.data[6:0];
          REG_DEFCOST: dcost_r  <= cfg_s.data[COST_BITS-1:0];
          default: ;
        endcase
        gc_r   <= '0;
        gr_r   <= '0;
        di_r   <= '0;
        ring_r <= '0;
        best_r <= '1;
        bidx_r <= '0;
      end else begin
        if (accept) begin
          if (di_last) begin
            di_r <= '0;
            if (col_last) begin
              gc_r <= '0;
              if (row_last) begin
                gr_r   <= '0;
                ring_r <= '0;
              end else begin
                gr_r   <= gr_r + ROW_W'(1);
                ring_r <= (ring_r == RING_W'(RING_ROWS - 1)) ? '0 : ring_r + RING_W'(1);
              end
            end else begin
              gc_r <= gc_r + COL_W'(1);
            end
          end else begin
            di_r <= di_r + DISP_W'(1);
          end
        end
        if (advance) begin
          best_r <= best_nxt;
          bidx_r <= bidx_nxt;
        end
      end
      if (advance) begin
        s1_v_r  <= accept;
        s2_v_r  <= s1_v_r;
        out_v_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cost_r <= cost_in;
      s1_gc_r   <= gc_r;
      s1_di_r   <= di_r;
      s1_f_r    <= s1_f_nxt;
    end
    if (s1_wr) begin
      fwd_v_r   <= v_new;
      fwd_w_r   <= w_new;
      s2_w_r    <= w_new;
      s2_di_r   <= s1_di_r;
      s2_zone_r <= s1_f_r.zone;
      s2_last_r <= s1_f_r.last;
      s2_fend_r <= s1_f_r.fend;
    end
    if (advance && emit) begin
      out_disp_r <= {base_r[6], base_r} + {2'b00, cand_i};
      out_cost_r <= cand_c;
      out_fend_r <= s2_fend_r;
    end
  end

  assign out_m.valid            = out_v_r;
  assign out_m.best_disparity   = out_disp_r;
  assign out_m.best_window_cost = out_cost_r;
  assign out_m.frame_end        = out_fend_r;

endmodule
`default_nettype wire
